// ===== sv/upc_pkg.sv =====
// Shared types and constants for the URL percent codec.
// Holds the port payload structs, the front-to-back command and the queue depth.
// No dependencies.
`default_nettype none

package upc_pkg;

    // Default depth of the command queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Characters the codec recognizes.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Direction register values.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_end;
        logic       bad_input;
    } out_item_t;

    // A single command gives one result; an escape command gives '%' and two hex digits.
    typedef enum logic {
        CMD_SINGLE = 1'b0,
        CMD_ESCAPE = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
        logic       last;
        logic       bad;
    } cmd_t;

endpackage

`default_nettype wire

// ===== sv/upc_front.sv =====
// Front part of the URL percent codec: accepts characters and classifies them.
// Holds the direction register and the decode and discard state; emits commands.
// Depends on upc_pkg.
`default_nettype none

module upc_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_data,
    input  wire logic              accept,
    input  wire upc_pkg::in_item_t in_item,
    output upc_pkg::cmd_t          cmd,
    output logic                   cmd_valid
);

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] nibble_reg, nibble_next;
    logic       discard_reg, discard_next;
    logic       direction_reg;

    logic [7:0] c;
    logic       e;
    logic [3:0] hexv;
    logic       clear_char;

    function automatic logic [3:0] hex_value(input logic [7:0] x);
        logic [3:0] v;
        v = 4'd0;
        if (x >= 8'h30 && x <= 8'h39)
            v = 4'(x - 8'h30);
        else if (x >= 8'h41 && x <= 8'h46)
            v = 4'(x - 8'h37);
        else if (x >= 8'h61 && x <= 8'h66)
            v = 4'(x - 8'h57);
        return v;
    endfunction

    assign c    = in_item.in_char;
    assign e    = in_item.in_end;
    assign hexv = hex_value(c);

    // Letters, digits and _ . : / travel through encoding unchanged.
    assign clear_char = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
                     || (c >= 8'h30 && c <= 8'h39) || c == 8'h5F || c == 8'h2E
                     || c == 8'h3A || c == 8'h2F;

    always_comb
    begin
        phase_next   = phase_reg;
        nibble_next  = nibble_reg;
        discard_next = discard_reg;
        cmd_valid    = 1'b0;
        cmd.kind     = upc_pkg::CMD_SINGLE;
        cmd.ch       = c;
        cmd.last     = e;
        cmd.bad      = 1'b0;

        if (discard_reg)
        begin
            if (e)
                discard_next = 1'b0;
        end
        else if (direction_reg == upc_pkg::DIR_ENCODE)
        begin
            phase_next  = PH_PLAIN;
            nibble_next = 4'd0;
            cmd_valid   = 1'b1;
            if (c[7])
            begin
                discard_next = !e;
                cmd.ch       = 8'd0;
                cmd.last     = 1'b1;
                cmd.bad      = 1'b1;
            end
            else if (c == upc_pkg::CH_SPACE)
                cmd.ch = upc_pkg::CH_PLUS;
            else if (!clear_char)
                cmd.kind = upc_pkg::CMD_ESCAPE;
        end
        else
        begin
            unique case (phase_reg)
                PH_HIGH:
                begin
                    if (e)
                    begin
                        phase_next  = PH_PLAIN;
                        nibble_next = 4'd0;
                        cmd_valid   = 1'b1;
                        cmd.ch      = 8'd0;
                        cmd.bad     = 1'b1;
                    end
                    else
                    begin
                        nibble_next = hexv;
                        phase_next  = PH_LOW;
                    end
                end
                PH_LOW:
                begin
                    phase_next  = PH_PLAIN;
                    nibble_next = 4'd0;
                    cmd_valid   = 1'b1;
                    cmd.ch      = {nibble_reg, hexv};
                end
                default:
                begin
                    phase_next = PH_PLAIN;
                    if (c[7] || (c == upc_pkg::CH_PERCENT && e))
                    begin
                        nibble_next  = 4'd0;
                        discard_next = !e;
                        cmd_valid    = 1'b1;
                        cmd.ch       = 8'd0;
                        cmd.last     = 1'b1;
                        cmd.bad      = 1'b1;
                    end
                    else if (c == upc_pkg::CH_PERCENT)
                        phase_next = PH_HIGH;
                    else
                    begin
                        cmd_valid = 1'b1;
                        if (c == upc_pkg::CH_PLUS)
                            cmd.ch = upc_pkg::CH_SPACE;
                    end
                end
            endcase
        end

        if (!accept)
        begin
            phase_next   = phase_reg;
            nibble_next  = nibble_reg;
            discard_next = discard_reg;
            cmd_valid    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PLAIN;
            nibble_reg    <= 4'd0;
            discard_reg   <= 1'b0;
            direction_reg <= upc_pkg::DIR_ENCODE;
        end
        else
        begin
            phase_reg   <= phase_next;
            nibble_reg  <= nibble_next;
            discard_reg <= discard_next;
            if (cfg_we)
                direction_reg <= cfg_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/upc_queue.sv =====
// Short command queue between the front and back parts of the URL percent codec.
// A flop array with read and write pointers and an occupancy count.
// Depends on upc_pkg.
`default_nettype none

module upc_queue
#(
    parameter int unsigned DEPTH = upc_pkg::QUEUE_DEPTH
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire upc_pkg::cmd_t  wr_data,
    input  wire logic           rd_en,
    output upc_pkg::cmd_t       rd_data,
    output logic                not_empty,
    output logic                full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    upc_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign rd_data   = mem_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign full      = count_reg == CNT_W'(DEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/upc_back.sv =====
// Back part of the URL percent codec: expands commands into result items.
// Steps through the three results of an escape and holds the output register.
// Depends on upc_pkg.
`default_nettype none

module upc_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire upc_pkg::cmd_t      cmd,
    input  wire logic               cmd_valid,
    output logic                    cmd_pop,
    input  wire logic               pop,
    output logic                    empty,
    output upc_pkg::out_item_t      out_item
);

    typedef enum logic [1:0] {
        STEP_FIRST  = 2'd0,
        STEP_HIGH   = 2'd1,
        STEP_LOW    = 2'd2
    } step_t;

    step_t              step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    upc_pkg::out_item_t out_item_reg, out_item_next;
    logic               load;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h37 + 8'(v);
    endfunction

    // The output register refills when it is empty or being taken.
    assign load = !out_valid_reg || pop;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        cmd_pop        = 1'b0;

        if (load)
        begin
            out_valid_next = cmd_valid;
            if (cmd_valid)
            begin
                out_item_next.out_char  = cmd.ch;
                out_item_next.out_end   = cmd.last;
                out_item_next.bad_input = cmd.bad;
                if (cmd.kind == upc_pkg::CMD_SINGLE)
                begin
                    cmd_pop   = 1'b1;
                    step_next = STEP_FIRST;
                end
                else
                begin
                    unique case (step_reg)
                        STEP_HIGH:
                        begin
                            out_item_next.out_char = hex_digit(cmd.ch[7:4]);
                            out_item_next.out_end  = 1'b0;
                            step_next              = STEP_LOW;
                        end
                        STEP_LOW:
                        begin
                            out_item_next.out_char = hex_digit(cmd.ch[3:0]);
                            cmd_pop                = 1'b1;
                            step_next              = STEP_FIRST;
                        end
                        default:
                        begin
                            out_item_next.out_char = upc_pkg::CH_PERCENT;
                            out_item_next.out_end  = 1'b0;
                            step_next              = STEP_HIGH;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_FIRST;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_item_reg;

endmodule

`default_nettype wire

// ===== sv/url_percent_codec.sv =====
// URL percent codec, top level. The front writes an item's command into
// the queue at the accepting edge; the output register loads it when empty or popped.
// Throughput: one item per cycle while results are taken; an escaped character
// gives three results, and the single output register sends one per cycle.
// Reset: clears the direction to encode, the decode and discard state, the
// command queue and the output register.
`default_nettype none

module url_percent_codec
#(
    parameter int unsigned QUEUE_DEPTH = upc_pkg::QUEUE_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire upc_pkg::in_item_t  in_item,
    output logic                    empty,
    input  wire logic               pop,
    output upc_pkg::out_item_t      out_item
);

    // The front takes an item whenever the command queue has room. Items that
    // are dropped or only update the hex-pair state produce no command.
    upc_pkg::cmd_t front_cmd;
    logic          front_cmd_valid;
    logic          accept;

    // The back reads the queue head, expanding each escape into three results.
    upc_pkg::cmd_t head_cmd;
    logic          head_valid;
    logic          head_pop;

    assign accept = push && !full;

    upc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_item   (in_item),
        .cmd       (front_cmd),
        .cmd_valid (front_cmd_valid)
    );

    // The queue decouples the two parts, so the front keeps accepting plain
    // characters while the back is still spelling out an escape.
    upc_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (front_cmd_valid),
        .wr_data   (front_cmd),
        .rd_en     (head_pop),
        .rd_data   (head_cmd),
        .not_empty (head_valid),
        .full      (full)
    );

    upc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (head_valid),
        .cmd_pop   (head_pop),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ===== bench/upc_codec_checker.sv =====
// Output checker for the URL percent codec: tracks the direction register,
// predicts the result items of every accepted input item and compares them.
// Depends on upc_pkg for the payload structs and character constants.
module upc_codec_checker
    import upc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic      cfg_data,
    input  wire logic      push,
    input  wire logic      full,
    input  wire in_item_t  in_item,
    input  wire logic      empty,
    input  wire logic      pop,
    input  wire out_item_t out_item,
    output int             fail_count,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        PH_PLAIN      = 2'd0,
        PH_FIRST_HEX  = 2'd1,
        PH_SECOND_HEX = 2'd2
    } dec_phase_t;

    logic       direction;
    dec_phase_t phase;
    logic [3:0] high_nib;
    logic       dropping;
    out_item_t  awaited_out[$];

    initial fail_count = 0;

    function automatic logic [3:0] hex_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
        if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
        return 4'h0;
    endfunction

    function automatic logic [7:0] hex_digit(logic [3:0] v);
        return {4'h0, v} + ((v < 4'd10) ? 8'h30 : 8'h37);
    endfunction

    task automatic emit(logic [7:0] ch, logic last, logic bad);
        awaited_out.push_back('{ch, last, bad});
    endtask

    // A rejected string gives one error item; unless the offending character
    // was the last one, the rest of the string is dropped.
    task automatic reject_string(logic last);
        phase    = PH_PLAIN;
        high_nib = 4'h0;
        dropping = !last;
        emit(8'h00, 1'b1, 1'b1);
    endtask

    task automatic codec_step(in_item_t it);
        logic [7:0] c;
        logic       e;
        c = it.in_char;
        e = it.in_end;
        if (dropping) begin
            if (e)
                dropping = 1'b0;
        end
        else if (direction == DIR_ENCODE) begin
            phase    = PH_PLAIN;
            high_nib = 4'h0;
            if (c[7])
                reject_string(e);
            else if (c == CH_SPACE)
                emit(CH_PLUS, e, 1'b0);
            else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                     (c >= "0" && c <= "9") || c == "_" || c == "." ||
                     c == ":" || c == "/")
                emit(c, e, 1'b0);
            else begin
                emit(CH_PERCENT, 1'b0, 1'b0);
                emit(hex_digit(c[7:4]), 1'b0, 1'b0);
                emit(hex_digit(c[3:0]), e, 1'b0);
            end
        end
        else if (phase == PH_FIRST_HEX) begin
            if (e)
                reject_string(e);
            else begin
                high_nib = hex_value(c);
                phase    = PH_SECOND_HEX;
            end
        end
        else if (phase == PH_SECOND_HEX) begin
            emit({high_nib, hex_value(c)}, e, 1'b0);
            phase    = PH_PLAIN;
            high_nib = 4'h0;
        end
        else begin
            if (c[7])
                reject_string(e);
            else if (c == CH_PLUS)
                emit(CH_SPACE, e, 1'b0);
            else if (c == CH_PERCENT) begin
                if (e)
                    reject_string(e);
                else
                    phase = PH_FIRST_HEX;
            end
            else
                emit(c, e, 1'b0);
        end
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (awaited_out.size() == 0) begin
            $error("unexpected item: out_char %h out_end %b bad_input %b",
                   got.out_char, got.out_end, got.bad_input);
            fail_count++;
        end
        else begin
            want = awaited_out.pop_front();
            if (got.out_char !== want.out_char) begin
                $error("out_char: expected %h, actual %h", want.out_char, got.out_char);
                fail_count++;
            end
            if (got.out_end !== want.out_end) begin
                $error("out_end: expected %b, actual %b", want.out_end, got.out_end);
                fail_count++;
            end
            if (got.bad_input !== want.bad_input) begin
                $error("bad_input: expected %b, actual %b", want.bad_input, got.bad_input);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            direction = DIR_ENCODE;
            phase     = PH_PLAIN;
            high_nib  = 4'h0;
            dropping  = 1'b0;
            awaited_out.delete();
        end
        else begin
            if (pop && !empty)
                check_result(out_item);
            if (cfg_we)
                direction = cfg_data;
            if (push && !full)
                codec_step(in_item);
        end
        pending = awaited_out.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the URL percent codec testbench: clock, reset, stimulus and verdict.
// Depends on upc_pkg, the url_percent_codec block and upc_codec_checker,
// which predicts and compares every result item.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import upc_pkg::*;

    // Length of the long receiver hold-off, in cycles. It is far longer than
    // the block can buffer, so the input side is forced to stall.
    localparam int LONG_HOLD = 80;

    // Idle cycles allowed before a direction write once no result is awaited.
    // A result passes through the command queue into the output register after its item
    // is accepted, and an item that gives no result only updates the front's decode state.
    localparam int SETTLE_CYCLES = 8;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_data;
    logic      push;
    logic      full;
    in_item_t  in_item;
    logic      empty;
    logic      pop;
    out_item_t out_item;

    int fail_count;
    int pending;

    // Each increment asks the receiver process for one long hold-off.
    int hold_req = 0;

    always #4 clk = ~clk;

    url_percent_codec uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    upc_codec_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .in_item    (in_item),
        .empty      (empty),
        .pop        (pop),
        .out_item   (out_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Gap lengths: mostly none, sometimes short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Characters for encode strings, weighted so that the pass-through set,
    // spaces, escaped ASCII and the rare non-ASCII error all show up.
    function automatic logic [7:0] pick_encode_char();
        string clear_set;
        string punct_set;
        int    r;
        clear_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
        punct_set = "_.:/";
        r = $urandom_range(0, 99);
        if (r < 35)
            return clear_set[$urandom_range(0, clear_set.len() - 1)];
        else if (r < 45)
            return CH_SPACE;
        else if (r < 55)
            return punct_set[$urandom_range(0, 3)];
        else if (r < 92)
            return 8'($urandom_range(0, 127));
        else
            return 8'($urandom_range(128, 255));
    endfunction

    // Offers one item after an optional gap and returns at the clock edge
    // where it was taken. Push is left high so a back-to-back item follows.
    task automatic send_char(logic [7:0] ch, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= '{ch, last};
        do
            @(posedge clk);
        while (full);
    endtask

    // Stops offering, waits until every predicted result item has been taken,
    // then lets the block settle so that it is idle.
    task automatic drain();
        push <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_direction(logic dir);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= dir;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Builds one string with random content and sends it. Decode strings are
    // mostly well formed: plain characters, plus signs and escape triplets with
    // valid hex digits. Some pairs hold non-hex or non-ASCII characters, a few
    // stray non-ASCII characters appear, and cutting the string at its length
    // can leave an escape unfinished.
    task automatic send_random_string(logic dir, int len);
        in_item_t   q[$];
        string      hx;
        logic [7:0] ch;
        int         r;
        hx = "0123456789abcdefABCDEF";
        while (q.size() < len) begin
            if (dir == DIR_ENCODE)
                q.push_back('{pick_encode_char(), 1'b0});
            else begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    q.push_back('{8'($urandom_range(0, 127)), 1'b0});
                else if (r < 65)
                    q.push_back('{CH_PLUS, 1'b0});
                else if (r < 95) begin
                    q.push_back('{CH_PERCENT, 1'b0});
                    repeat (2)
                    begin
                        if ($urandom_range(0, 9) != 0)
                            ch = hx[$urandom_range(0, hx.len() - 1)];
                        else
                            ch = 8'($urandom_range(0, 255));
                        q.push_back('{ch, 1'b0});
                    end
                end
                else
                    q.push_back('{8'($urandom_range(128, 255)), 1'b0});
            end
        end
        while (q.size() > len)
            void'(q.pop_back());
        q[len - 1].in_end = 1'b1;
        foreach (q[i])
            send_char(q[i].in_char, q[i].in_end);
    endtask

    // Receiver: random bursts of pop, random gaps, and a long hold-off whenever
    // the stimulus asks for one.
    initial
    begin : receiver
        int served;
        served = 0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req != served) begin
                served = hold_req;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                repeat (1 + pick_gap()) @(posedge clk);
            end
            else begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int sent;
        int len;
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= 1'b0;
        push     <= 1'b0;
        in_item  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Encode: space, pass-through, escapes of the lowest and highest ASCII
        // codes, then a non-ASCII character in mid-string whose string is dropped
        // up to its end mark, and a non-ASCII character that ends its string.
        set_direction(DIR_ENCODE);
        send_char("A", 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char("~", 1'b0);
        send_char(8'h00, 1'b0);
        send_char("/", 1'b0);
        send_char(8'h7F, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char("q", 1'b1);
        send_char(8'h80, 1'b1);

        // Decode: plus sign, escapes with upper and lower case digits, a pair
        // holding a non-ASCII and a non-hex character, a percent that ends the
        // string, a string cut after the first hex digit, and a stray non-ASCII
        // character followed by a dropped end mark.
        set_direction(DIR_DECODE);
        send_char(CH_PLUS, 1'b0);
        send_char(CH_PERCENT, 1'b0);
        send_char("4", 1'b0);
        send_char("1", 1'b0);
        send_char(CH_PERCENT, 1'b0);
        send_char("f", 1'b0);
        send_char("F", 1'b0);
        send_char(CH_PERCENT, 1'b0);
        send_char(8'hC3, 1'b0);
        send_char("G", 1'b1);
        send_char(CH_PERCENT, 1'b1);
        send_char(CH_PERCENT, 1'b0);
        send_char("3", 1'b1);
        send_char(8'h90, 1'b0);
        send_char("x", 1'b1);

        // An escape left half done when the direction flips to encode is
        // abandoned; the next character is encoded on its own.
        send_char(CH_PERCENT, 1'b0);
        send_char("4", 1'b0);
        set_direction(DIR_ENCODE);
        send_char("b", 1'b1);

        // Random strings in alternating directions. A phase always ends with a
        // whole string, so the next direction starts on a fresh one. Two
        // phases start with a long receiver hold-off so the block fills up.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_direction((ph % 2 == 0) ? DIR_DECODE : DIR_ENCODE);
            if (ph == 1 || ph == 4)
                hold_req <= hold_req + 1;
            sent = 0;
            while (sent < 21)
            begin
                len = $urandom_range(1, 8);
                send_random_string((ph % 2 == 0) ? DIR_DECODE : DIR_ENCODE, len);
                sent += len;
            end
        end

        drain();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // The slowest correct run stays well below the watchdog's limit.
    initial
    begin : watchdog
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
